// ===== rtl/core/bqc_pkg.sv =====
// Shared types, register indexes, constants and saturation helpers of the biquad cascade.
package bqc_pkg;

    // Sample format: signed fixed point with one integer bit.
    localparam int SampleBits = 16;
    localparam int FracBits   = SampleBits - 1;
    localparam int UpShift    = (SampleBits >= 16) ? SampleBits - 16 : 0;
    localparam int DownShift  = (SampleBits >= 16) ? 0 : 16 - SampleBits;

    typedef logic signed [SampleBits-1:0]   sample_t;
    typedef logic signed [SampleBits+1:0]   wide_t;
    typedef logic signed [2*SampleBits-1:0] prod_t;

    // Configuration register indexes.
    localparam int CfgIndexBits = 3;
    typedef logic [CfgIndexBits-1:0] cfg_index_t;
    localparam cfg_index_t REG_GAIN   = cfg_index_t'(0);
    localparam cfg_index_t REG_S1_FB1 = cfg_index_t'(1);
    localparam cfg_index_t REG_S1_FB2 = cfg_index_t'(2);
    localparam cfg_index_t REG_S2_FB1 = cfg_index_t'(3);
    localparam cfg_index_t REG_S2_FB2 = cfg_index_t'(4);

    // Limits of the sample range.
    localparam sample_t SampleMax = sample_t'((longint'(1) << FracBits) - 1);
    localparam sample_t SampleMin = sample_t'(-(longint'(1) << FracBits));

    // Fixed numerator coefficients.
    localparam sample_t Quarter = sample_t'(longint'(1) << (FracBits - 2));
    localparam sample_t Half    = sample_t'(longint'(1) << (FracBits - 1));
    localparam sample_t NegHalf = sample_t'(-(longint'(1) << (FracBits - 1)));

    // Brings a Q15 constant to the sample width, rounding toward minus infinity.
    function automatic sample_t rescale_q15(input longint v);
        if (SampleBits >= 16)
        begin
            return sample_t'(v <<< UpShift);
        end
        return sample_t'(v >>> DownShift);
    endfunction

    localparam sample_t GainReset  = rescale_q15(1011);
    localparam sample_t S1Fb1Reset = rescale_q15(14537);
    localparam sample_t S1Fb2Reset = rescale_q15(-7984);
    localparam sample_t S2Fb1Reset = rescale_q15(14858);
    localparam sample_t S2Fb2Reset = rescale_q15(-8003);

    // Clamps a widened value to the sample range.
    function automatic sample_t sat_sample(input wide_t v);
        if (v > wide_t'(SampleMax))
        begin
            return SampleMax;
        end
        if (v < wide_t'(SampleMin))
        begin
            return SampleMin;
        end
        return sample_t'(v);
    endfunction

    // Scales a full product back to the sample format with floor rounding and saturation.
    function automatic sample_t q_product(input prod_t p);
        prod_t s;
        s = p >>> FracBits;
        return sat_sample(wide_t'($signed(s[SampleBits:0])));
    endfunction

endpackage

// ===== rtl/core/biquad_cascade_iir_filter_unit.sv =====
// Two cascaded direct form 1 biquad sections sharing one multiplier.
//
// The block filters one signed Q15 sample at a time through a highpass section and then a
// lowpass section and delivers the second section's output. All sixteen products of a sample
// (three numerator products, three gain products and two feedback products per section) go
// through a single registered multiplier under a small sequencer: a multiply step forms each
// product and a second step scales and saturates it and keeps or accumulates it. A finishing
// step per section applies the times-four scale, and a hold step loads the output register,
// waiting while that register still holds an untaken result. in_stall is high from the edge
// that accepts a sample until the sequencer is idle again, so a new sample is not accepted
// before the previous result is loaded. The result waits in its own output register, so a new
// sample is accepted while the previous result is not yet taken. Configuration is written
// through cfg_we, cfg_index and cfg_data; the user must write it only while the block is idle,
// which the block does not enforce. Writes to indexes beyond the last register are ignored.
module biquad_cascade_iir_filter_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  bqc_pkg::cfg_index_t  cfg_index,
    input  bqc_pkg::sample_t     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bqc_pkg::sample_t     sample_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bqc_pkg::sample_t     sample_out
);
    import bqc_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    // Product steps within one section.
    localparam logic [2:0] OP_X0_NUM  = 3'd0;
    localparam logic [2:0] OP_X0_GAIN = 3'd1;
    localparam logic [2:0] OP_X1_NUM  = 3'd2;
    localparam logic [2:0] OP_X1_GAIN = 3'd3;
    localparam logic [2:0] OP_X2_NUM  = 3'd4;
    localparam logic [2:0] OP_X2_GAIN = 3'd5;
    localparam logic [2:0] OP_Y1_FB   = 3'd6;
    localparam logic [2:0] OP_Y2_FB   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic       sec_reg, sec_next;

    sample_t gain_reg, gain_next;
    sample_t s1_fb1_reg, s1_fb1_next;
    sample_t s1_fb2_reg, s1_fb2_next;
    sample_t s2_fb1_reg, s2_fb1_next;
    sample_t s2_fb2_reg, s2_fb2_next;

    sample_t xd0_reg, xd0_next;
    sample_t xd1_reg, xd1_next;
    sample_t s1d0_reg, s1d0_next;
    sample_t s1d1_reg, s1d1_next;
    sample_t s2d0_reg, s2d0_next;
    sample_t s2d1_reg, s2d1_next;

    logic    out_valid_reg, out_valid_next;
    sample_t out_reg, out_next;
    sample_t x_reg, x_next;
    sample_t y1_reg, y1_next;
    sample_t y2_reg, y2_next;
    sample_t tmp_reg, tmp_next;
    sample_t acc_reg, acc_next;
    prod_t   prod_reg, prod_next;

    sample_t op_a;
    sample_t op_b;
    sample_t q_val;
    sample_t acc_sum;
    sample_t sec_out;
    logic    in_beat;
    logic    out_free;

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;
    assign in_beat    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (op_reg)
            OP_X0_NUM:
            begin
                op_a = sec_reg ? y1_reg : x_reg;
                op_b = Quarter;
            end
            OP_X1_NUM:
            begin
                op_a = sec_reg ? s1d0_reg : xd0_reg;
                op_b = sec_reg ? Half : NegHalf;
            end
            OP_X2_NUM:
            begin
                op_a = sec_reg ? s1d1_reg : xd1_reg;
                op_b = Quarter;
            end
            OP_X0_GAIN, OP_X1_GAIN, OP_X2_GAIN:
            begin
                op_a = tmp_reg;
                op_b = gain_reg;
            end
            OP_Y1_FB:
            begin
                op_a = sec_reg ? s2d0_reg : s1d0_reg;
                op_b = sec_reg ? s2_fb1_reg : s1_fb1_reg;
            end
            OP_Y2_FB:
            begin
                op_a = sec_reg ? s2d1_reg : s1d1_reg;
                op_b = sec_reg ? s2_fb2_reg : s1_fb2_reg;
            end
            default:
            begin
                op_a = tmp_reg;
                op_b = gain_reg;
            end
        endcase
    end

    // Scaling, accumulation and the section's times-four output.
    assign q_val   = q_product(prod_reg);
    assign acc_sum = sat_sample(wide_t'(acc_reg) + wide_t'(q_val));
    assign sec_out = sat_sample(wide_t'(acc_reg) <<< 2);

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        sec_next       = sec_reg;
        gain_next      = gain_reg;
        s1_fb1_next    = s1_fb1_reg;
        s1_fb2_next    = s1_fb2_reg;
        s2_fb1_next    = s2_fb1_reg;
        s2_fb2_next    = s2_fb2_reg;
        xd0_next       = xd0_reg;
        xd1_next       = xd1_reg;
        s1d0_next      = s1d0_reg;
        s1d1_next      = s1d1_reg;
        s2d0_next      = s2d0_reg;
        s2d1_next      = s2d1_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        x_next         = x_reg;
        y1_next        = y1_reg;
        y2_next        = y2_reg;
        tmp_next       = tmp_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;

        // Configuration writes.
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN:   gain_next   = cfg_data;
                REG_S1_FB1: s1_fb1_next = cfg_data;
                REG_S1_FB2: s1_fb2_next = cfg_data;
                REG_S2_FB1: s2_fb1_next = cfg_data;
                REG_S2_FB2: s2_fb2_next = cfg_data;
                default:    ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    x_next     = sample_in;
                    acc_next   = '0;
                    op_next    = OP_X0_NUM;
                    sec_next   = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = op_a * op_b;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (op_reg == OP_X0_NUM || op_reg == OP_X1_NUM || op_reg == OP_X2_NUM)
                begin
                    tmp_next = q_val;
                end
                else
                begin
                    acc_next = acc_sum;
                end
                if (op_reg == OP_Y2_FB)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    op_next    = op_reg + 3'd1;
                    state_next = ST_MUL;
                end
            end
            ST_FIN:
            begin
                if (!sec_reg)
                begin
                    y1_next    = sec_out;
                    acc_next   = '0;
                    op_next    = OP_X0_NUM;
                    sec_next   = 1'b1;
                    state_next = ST_MUL;
                end
                else
                begin
                    // Both sections done: shift every delay line.
                    y2_next    = sec_out;
                    xd1_next   = xd0_reg;
                    xd0_next   = x_reg;
                    s1d1_next  = s1d0_reg;
                    s1d0_next  = y1_reg;
                    s2d1_next  = s2d0_reg;
                    s2d0_next  = sec_out;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_next       = y2_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_X0_NUM;
            sec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            gain_reg      <= GainReset;
            s1_fb1_reg    <= S1Fb1Reset;
            s1_fb2_reg    <= S1Fb2Reset;
            s2_fb1_reg    <= S2Fb1Reset;
            s2_fb2_reg    <= S2Fb2Reset;
            xd0_reg       <= '0;
            xd1_reg       <= '0;
            s1d0_reg      <= '0;
            s1d1_reg      <= '0;
            s2d0_reg      <= '0;
            s2d1_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            sec_reg       <= sec_next;
            out_valid_reg <= out_valid_next;
            gain_reg      <= gain_next;
            s1_fb1_reg    <= s1_fb1_next;
            s1_fb2_reg    <= s1_fb2_next;
            s2_fb1_reg    <= s2_fb1_next;
            s2_fb2_reg    <= s2_fb2_next;
            xd0_reg       <= xd0_next;
            xd1_reg       <= xd1_next;
            s1d0_reg      <= s1d0_next;
            s1d1_reg      <= s1d1_next;
            s2d0_reg      <= s2d0_next;
            s2d1_reg      <= s2d1_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        x_reg    <= x_next;
        y1_reg   <= y1_next;
        y2_reg   <= y2_next;
        tmp_reg  <= tmp_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    // An accepted beat starts the first section with a cleared accumulator.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> state_reg == ST_MUL && op_reg == OP_X0_NUM && !sec_reg && acc_reg == '0)
        else $error("sequencer did not start cleanly on an input beat");

    // Every multiply is followed by its accumulate step.
    a_mul_add: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |=> state_reg == ST_ADD)
        else $error("multiply step not followed by accumulate step");

    // A section only finishes after its last feedback product.
    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |-> $past(state_reg) == ST_ADD && $past(op_reg) == OP_Y2_FB)
        else $error("section finished before all products were taken");

    // A new result only appears from the hold state.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_HOLD)
        else $error("result raised outside the hold state");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the two-section biquad cascade filter with a bit-exact predictor.
module tb;
    import bqc_pkg::*;

    localparam int ClockPeriod   = 10;
    localparam int ResetCycles   = 7;
    localparam int StallLimit    = 3000;
    localparam int HoldOffCycles = 400;
    localparam int DrainCycles   = 60;
    localparam int RandomPhases  = 12;
    localparam int PhaseSamples  = 130;
    localparam int ReportLimit   = 10;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    cfg_index_t cfg_index = REG_GAIN;
    sample_t    cfg_data  = '0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    sample_t    sample_in = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    sample_t    sample_out;

    // Coefficients and delay lines as the testbench expects the block to hold them.
    sample_t coef_gain   = GainReset;
    sample_t coef_s1_fb1 = S1Fb1Reset;
    sample_t coef_s1_fb2 = S1Fb2Reset;
    sample_t coef_s2_fb1 = S2Fb1Reset;
    sample_t coef_s2_fb2 = S2Fb2Reset;
    sample_t x_hist[2]   = '{'0, '0};
    sample_t s1_hist[2]  = '{'0, '0};
    sample_t s2_hist[2]  = '{'0, '0};

    sample_t pending_samples[$];
    sample_t expected_outputs[$];
    sample_t want_sample;
    int      samples_queued = 0;
    int      samples_taken  = 0;
    int      send_idle_max  = 0;
    int      recv_idle_max  = 0;
    int      send_gap       = 0;
    int      recv_wait      = 0;
    int      hold_requests  = 0;
    int      holds_served   = 0;
    int      hold_left      = 0;
    int      mismatches     = 0;
    int      idle_cycles    = 0;

    biquad_cascade_iir_filter_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

    always #(ClockPeriod / 2) clk = ~clk;

    // Clamps an exact value to the sample range.
    function automatic sample_t clamp_sample(input longint v);
        if (v > longint'(SampleMax))
            return SampleMax;
        if (v < longint'(SampleMin))
            return SampleMin;
        return sample_t'(v);
    endfunction

    // Fractional multiply: exact product, floor shift, then saturation.
    function automatic sample_t frac_mul(input sample_t a, input sample_t b);
        return clamp_sample((longint'(a) * longint'(b)) >>> FracBits);
    endfunction

    // One direct form 1 section; every partial sum saturates, then the sum is scaled by four.
    function automatic sample_t biquad_section(input sample_t x0, input sample_t x1,
                                               input sample_t x2, input sample_t y1,
                                               input sample_t y2, input sample_t n0,
                                               input sample_t n1, input sample_t n2,
                                               input sample_t fb1, input sample_t fb2);
        longint acc;
        acc = frac_mul(frac_mul(x0, n0), coef_gain);
        acc = clamp_sample(acc + frac_mul(frac_mul(x1, n1), coef_gain));
        acc = clamp_sample(acc + frac_mul(frac_mul(x2, n2), coef_gain));
        acc = clamp_sample(acc + frac_mul(y1, fb1));
        acc = clamp_sample(acc + frac_mul(y2, fb2));
        return clamp_sample(acc * 4);
    endfunction

    // Runs one sample through the highpass and lowpass sections and records the output.
    task automatic filter_sample(input sample_t x);
        sample_t y1;
        sample_t y2;
        y1 = biquad_section(x, x_hist[0], x_hist[1], s1_hist[0], s1_hist[1],
                            Quarter, NegHalf, Quarter, coef_s1_fb1, coef_s1_fb2);
        y2 = biquad_section(y1, s1_hist[0], s1_hist[1], s2_hist[0], s2_hist[1],
                            Quarter, Half, Quarter, coef_s2_fb1, coef_s2_fb2);
        x_hist[1]  = x_hist[0];
        x_hist[0]  = x;
        s1_hist[1] = s1_hist[0];
        s1_hist[0] = y1;
        s2_hist[1] = s2_hist[0];
        s2_hist[0] = y2;
        expected_outputs.push_back(y2);
    endtask

    // Half full-range samples, some of reduced amplitude, some at the rails.
    function automatic sample_t draw_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return sample_t'($urandom);
        if (pick < 8)
            return sample_t'($urandom) >>> $urandom_range(2, 10);
        if (pick == 8)
            return SampleMax;
        return SampleMin;
    endfunction

    // A coefficient near its nominal value, at an extreme, zero or anywhere.
    function automatic sample_t draw_coef(input sample_t nominal);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return SampleMax;
        if (pick == 1)
            return SampleMin;
        if (pick == 2)
            return '0;
        if (pick < 7)
            return nominal + sample_t'($urandom_range(0, 2047)) - sample_t'(1024);
        return sample_t'($urandom);
    endfunction

    // Writes one register and updates the predicted copy; unused indexes change nothing.
    task automatic write_reg(input cfg_index_t idx, input sample_t value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_GAIN:   coef_gain   = value;
            REG_S1_FB1: coef_s1_fb1 = value;
            REG_S1_FB2: coef_s1_fb2 = value;
            REG_S2_FB1: coef_s2_fb1 = value;
            REG_S2_FB2: coef_s2_fb2 = value;
            default: ;
        endcase
    endtask

    // Loads all five registers plus one write to an index past the last register.
    task automatic load_coefficients(input sample_t g, input sample_t a1, input sample_t a2,
                                     input sample_t b1, input sample_t b2);
        write_reg(cfg_index_t'(int'(REG_S2_FB2)
                  + $urandom_range(1, (1 << CfgIndexBits) - 1 - int'(REG_S2_FB2))),
                  sample_t'($urandom));
        write_reg(REG_GAIN, g);
        write_reg(REG_S1_FB1, a1);
        write_reg(REG_S1_FB2, a2);
        write_reg(REG_S2_FB1, b1);
        write_reg(REG_S2_FB2, b2);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_sample(input sample_t s);
        pending_samples.push_back(s);
        samples_queued++;
    endtask

    // Returns once every queued sample is taken and every output has arrived.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (samples_taken != samples_queued || expected_outputs.size() != 0);
    endtask

    // Input driver: presents queued samples with a random gap after each beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            sample_in <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                filter_sample(sample_in);
                samples_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    in_valid  <= 1'b1;
                    sample_in <= pending_samples.pop_front();
                    send_gap = $urandom_range(0, send_idle_max);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each beat against the oldest prediction and paces the stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_outputs.size() == 0)
                begin
                    if (mismatches < ReportLimit)
                        $display("Output beat %0d arrived with nothing expected", sample_out);
                    mismatches++;
                end
                else
                begin
                    want_sample = expected_outputs.pop_front();
                    if (sample_out !== want_sample)
                    begin
                        if (mismatches < ReportLimit)
                            $display("sample_out mismatch: expected %0d, got %0d",
                                     want_sample, sample_out);
                        mismatches++;
                    end
                end
                recv_wait = $urandom_range(0, recv_idle_max);
            end
            // A long hold-off lets the block back up into its input.
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left = HoldOffCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= StallLimit)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Stimulus sequence: directed probes first, then randomized coefficient phases.
    initial
    begin
        sample_t reset_probe[10];
        sample_t rail_probe[8];
        sample_t gain_probe[6];
        int phase;

        reset_probe = '{SampleMax, SampleMax, SampleMax, SampleMin, SampleMin, SampleMin,
                        sample_t'(0), sample_t'(1), sample_t'(-1), sample_t'(16'h5555)};
        rail_probe  = '{SampleMax, SampleMax, SampleMax, SampleMin, SampleMin, SampleMin,
                        sample_t'(0), sample_t'(16'hAAAA)};
        gain_probe  = '{SampleMin, SampleMin, SampleMax, SampleMax, sample_t'(0),
                        sample_t'(12345)};

        repeat (ResetCycles) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset coefficients: step response and alternating bit patterns.
        foreach (reset_probe[i])
            queue_sample(reset_probe[i]);
        wait_until_drained();

        // Most negative feedback drives the sections to the rails, so the most negative
        // value gets squared in the feedback products.
        send_idle_max = 7;
        recv_idle_max = 7;
        load_coefficients(SampleMax, SampleMin, SampleMin, SampleMin, SampleMin);
        foreach (rail_probe[i])
            queue_sample(rail_probe[i]);
        wait_until_drained();

        // Most negative gain with the largest positive feedback.
        load_coefficients(SampleMin, SampleMax, SampleMax, SampleMax, SampleMax);
        foreach (gain_probe[i])
            queue_sample(gain_probe[i]);
        wait_until_drained();

        // Random phases; every third one runs the nominal filter.
        for (phase = 0; phase < RandomPhases; phase++)
        begin
            if (phase % 3 == 0)
                load_coefficients(GainReset, S1Fb1Reset, S1Fb2Reset, S2Fb1Reset, S2Fb2Reset);
            else
                load_coefficients(draw_coef(GainReset), draw_coef(S1Fb1Reset),
                                  draw_coef(S1Fb2Reset), draw_coef(S2Fb1Reset),
                                  draw_coef(S2Fb2Reset));
            send_idle_max = (phase % 3 == 1) ? 0 : 7;
            recv_idle_max = (phase % 4 == 3) ? 0 : 7;
            repeat (PhaseSamples)
                queue_sample(draw_sample());
            if (phase == 2)
            begin
                send_idle_max = 0;
                hold_requests++;
            end
            wait_until_drained();
        end

        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0 && expected_outputs.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bqc_pkg.sv
rtl/core/biquad_cascade_iir_filter_unit.sv
tb/tb.sv
